[hdl/merge_sort_engine_assert.svh]
// Assertion macros used by the merge sort engine checker
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset
`define MSE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hdl/mse_pkg.sv]
// Shared types and constants of the merge sort engine
package mse_pkg;

  localparam int unsigned DataW = 32;

  // Source of the data written into a store bank
  typedef enum logic [1:0] {
    WSEL_INPUT = 2'd0,
    WSEL_LEFT  = 2'd1,
    WSEL_RIGHT = 2'd2
  } wsel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  wr_en;
    logic  wr_bank;
    wsel_e wr_sel;
    logic  rd_en;
    logic  rd_bank;
  } dp_cmd_t;

endpackage

[hdl/merge_sort_engine.sv]
// Top level of the merge sort engine: controller plus banked datapath
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  input   | in_valid_i / in_ready_o    | value_i, last_in_i
//  output  | out_valid_o / out_ready_i  | sorted_value_o, last_out_o, dropped_o
//
// Loading accepts one value per cycle. A set of N values then sorts in
// ceil(log2 N) passes; for each element a pass reads both run heads
// from the bank, then compares and writes, plus a setup step per run. Each
// result is read from the bank, then held until taken; only then is the
// next one read. No clearing pass after reset. Input is refused while a set
// sorts or drains; a stalled output simply holds the result and the sequencer.
module merge_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [mse_pkg::DataW-1:0] value_i,
  input  logic                             last_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mse_pkg::DataW-1:0] sorted_value_o,
  output logic                             last_out_o,
  output logic                             dropped_o
);
  import mse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  dp_cmd_t       cmd;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic          a_le_b;

  mse_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_out_o  (last_out_o),
    .dropped_o   (dropped_o),
    .a_le_b_i    (a_le_b),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b)
  );

  mse_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .value_i     (value_i),
    .a_le_b_o    (a_le_b),
    .rd_a_o      (sorted_value_o)
  );

endmodule

[hdl/mse_datapath.sv]
// Datapath: two ping-pong element banks, registered reads and the merge compare
module mse_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mse_pkg::dp_cmd_t                    cmd_i,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_b_i,
  input  logic signed [mse_pkg::DataW-1:0]    value_i,
  output logic                                a_le_b_o,
  output logic signed [mse_pkg::DataW-1:0]    rd_a_o
);
  import mse_pkg::*;

  logic [DataW-1:0] bank0_mem [DEPTH];
  logic [DataW-1:0] bank1_mem [DEPTH];
  logic [DataW-1:0] b0a_q, b0b_q, b1a_q, b1b_q;
  logic             rd_bank_q;
  logic [DataW-1:0] wr_data;
  logic signed [DataW-1:0] rd_b;

  // write data: new value on load, else the head chosen by the merge
  always_comb begin
    case (cmd_i.wr_sel)
      WSEL_INPUT: wr_data = value_i;
      WSEL_LEFT:  wr_data = rd_a_o;
      WSEL_RIGHT: wr_data = rd_b;
      default:    wr_data = value_i;
    endcase
  end

  // bank 0: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_bank) begin
      bank0_mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      b0a_q <= bank0_mem[rd_addr_a_i];
      b0b_q <= bank0_mem[rd_addr_b_i];
    end
  end

  // bank 1: same arrangement
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_bank) begin
      bank1_mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      b1a_q <= bank1_mem[rd_addr_a_i];
      b1b_q <= bank1_mem[rd_addr_b_i];
    end
  end

  // remember which bank the held read data came from
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_bank_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      rd_bank_q <= cmd_i.rd_bank;
    end
  end

  assign rd_a_o   = rd_bank_q ? b1a_q : b0a_q;
  assign rd_b     = rd_bank_q ? b1b_q : b0b_q;
  // left head wins on equal values, keeping the sort stable
  assign a_le_b_o = (rd_a_o <= rd_b);

endmodule

[hdl/mse_ctrl.sv]
// Controller: load counting, bottom-up merge sequencing and result emission
module mse_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          last_out_o,
  output logic                          dropped_o,
  input  logic                          a_le_b_i,
  output mse_pkg::dp_cmd_t              cmd_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_a_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_b_o
);
  import mse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 2;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_RUN   = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_ORD   = 6'b010000,
    S_OWAIT = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          pass_q, pass_d;
  logic [CW:0]   width_q, width_d;
  logic [CW-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  logic [IW-1:0] n_w, width_w, mid_s, hi_s, next_lo;
  logic          take_left, last_res;

  // run bounds for the current lo and width
  always_comb begin
    n_w     = IW'(cnt_q);
    width_w = IW'(width_q);
    mid_s   = IW'(lo_q) + width_w;
    hi_s    = IW'(lo_q) + (width_w << 1);
    next_lo = hi_s;
  end

  assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || a_le_b_i);
  assign last_res  = ({1'b0, k_q} + 1'b1) == {1'b0, cnt_q};

  // next-state and command logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pass_d      = pass_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cmd_o       = '0;
    cmd_o.wr_sel = WSEL_INPUT;
    wr_addr_o   = k_q[AW-1:0];
    rd_addr_a_o = i_q[AW-1:0];
    rd_addr_b_o = j_q[AW-1:0];
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CW'(DEPTH)) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_bank = 1'b0;
            cmd_o.wr_sel  = WSEL_INPUT;
            wr_addr_o     = cnt_q[AW-1:0];
            cnt_d         = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_in_i) begin
            pass_d  = 1'b0;
            width_d = (CW+1)'(1);
            lo_d    = '0;
            k_d     = '0;
            state_d = (cnt_d > CW'(1)) ? S_RUN : S_ORD;
          end
        end
      end
      S_RUN: begin
        mid_d   = (mid_s > n_w) ? cnt_q : mid_s[CW-1:0];
        hi_d    = (hi_s > n_w) ? cnt_q : hi_s[CW-1:0];
        i_d     = lo_q;
        j_d     = (mid_s > n_w) ? cnt_q : mid_s[CW-1:0];
        k_d     = lo_q;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_bank = pass_q;
        state_d       = S_WR;
      end
      S_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_bank = ~pass_q;
        cmd_o.wr_sel  = take_left ? WSEL_LEFT : WSEL_RIGHT;
        k_d = k_q + 1'b1;
        if (take_left) begin
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (({1'b0, k_q} + 1'b1) == {1'b0, hi_q}) begin
          // run finished
          if (next_lo >= n_w) begin
            // pass finished: swap banks and double the run width
            pass_d  = ~pass_q;
            width_d = width_q << 1;
            if ((width_w << 1) >= n_w) begin
              k_d     = '0;
              state_d = S_ORD;
            end else begin
              lo_d    = '0;
              state_d = S_RUN;
            end
          end else begin
            lo_d    = next_lo[CW-1:0];
            state_d = S_RUN;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_ORD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_bank = pass_q;
        rd_addr_a_o   = k_q[AW-1:0];
        state_d       = S_OWAIT;
      end
      S_OWAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_res) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign last_out_o = last_res;
  assign dropped_o  = ovf_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pass_q  <= 1'b0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pass_q  <= pass_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule

[hdl/mse_checker.sv]
// Port-level checker for the merge sort engine and its bind
`include "merge_sort_engine_assert.svh"

module mse_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic signed [mse_pkg::DataW-1:0] value_i,
  input logic                             last_in_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [mse_pkg::DataW-1:0] sorted_value_o,
  input logic                             last_out_o,
  input logic                             dropped_o
);
  import mse_pkg::*;

  // loading and emitting never overlap
  `MSE_ASSERT_NEVER(a_load_emit_excl, in_ready_o && out_valid_o, "load and emit overlap")

  // a closing input transaction stops further loading
  `MSE_ASSERT(a_last_in_closes, (in_valid_i && in_ready_o && last_in_i) |=> !in_ready_o, "input taken after set end")

  // after the final result the block returns to loading, with no stray result
  `MSE_ASSERT(a_last_out_ends, (out_valid_o && out_ready_i && last_out_o) |=> (!out_valid_o && in_ready_o), "result after set end")

  // a stalled result holds its value and flags
  `MSE_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sorted_value_o) && $stable(last_out_o) && $stable(dropped_o)), "stalled result changed")

  // a waiting input transaction keeps its payload
  `MSE_ASSERT(a_in_hold, (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(value_i) && $stable(last_in_i)), "waiting input changed")

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);
